// ----- design/pbrm_pkg.sv -----
// ----------------------------------------------------------------------------
// pbrm_pkg
// Shared types and constants for the packet byte rule matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package pbrm_pkg;
    localparam int RULE_COUNT   = 16;
    localparam int TERM_COUNT   = 16;
    localparam int BEAT_BYTES   = 8;
    localparam int OFFSET_BITS  = 12;
    localparam int MASK_BITS    = 16;
    localparam int START_BITS   = 16;
    localparam int DATA_BITS    = 64;
    localparam int DEST_BITS    = 32;
    localparam int REL_BITS     = 3;
    localparam int COUNT_BITS   = 5;
    localparam int IDX_BITS     = 4;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [1:0] {
        REQ_BEAT = 2'd0,
        REQ_RULE = 2'd1,
        REQ_TERM = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CMP_EQ    = 2'd0,
        CMP_LT    = 2'd1,
        CMP_GT    = 2'd2,
        CMP_NEVER = 2'd3
    } t_cmp;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_AND_MASK    = 3'd0,
        CFG_OR_MASK     = 3'd1,
        CFG_AND_OR_EN   = 3'd2,
        CFG_SOP_EN      = 3'd3,
        CFG_TERM_EN     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [7:0]             value;
        t_cmp                   compare;
        logic [DEST_BITS-1:0]   dest;
        logic                   enable;
    } t_rule;

    typedef struct packed {
        logic                  take;
        logic                  last;
        logic [DATA_BITS-1:0]  data;
        logic [BEAT_BYTES-1:0] keep;
        logic [START_BITS-1:0] start;
    } t_beat;

    typedef struct packed {
        logic [MASK_BITS-1:0] and_mask;
        logic [MASK_BITS-1:0] or_mask;
        logic                 and_or_en;
        logic                 sop_en;
        logic [MASK_BITS-1:0] term_en;
    } t_cfg;
endpackage
`default_nettype wire

// ----- design/packet_byte_rule_matcher.sv -----
// ----------------------------------------------------------------------------
// packet_byte_rule_matcher
// Row of rule cells matching packet bytes, with a serialized result stage.
//
// channel | direction | handshake           | payload
// input   | in        | i_valid / o_ready   | i_req_type .. i_term_mask
// result  | out       | o_valid / i_ready   | o_dest_addr .. o_last_result
// config  | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// Writes and beats are accepted back to back. A last beat yields
// max(1, matches) results, one per cycle while i_ready is high, from the
// snapshot stage; the next last beat waits only for that stage to drain.
// Synchronous reset clears rules to disabled, terms and config to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module packet_byte_rule_matcher import pbrm_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [MASK_BITS-1:0]     i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [DATA_BITS-1:0]     i_beat_data,
    input  wire logic [BEAT_BYTES-1:0]    i_beat_keep,
    input  wire logic                     i_beat_last,
    input  wire logic [IDX_BITS-1:0]      i_table_index,
    input  wire logic [OFFSET_BITS-1:0]   i_rule_offset,
    input  wire logic [7:0]               i_rule_value,
    input  wire logic [1:0]               i_rule_compare,
    input  wire logic [DEST_BITS-1:0]     i_rule_dest,
    input  wire logic                     i_rule_enable,
    input  wire logic [MASK_BITS-1:0]     i_term_mask,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [DEST_BITS-1:0]          o_dest_addr,
    output logic                          o_dest_valid,
    output logic [MASK_BITS-1:0]          o_matched_rules,
    output logic [COUNT_BITS-1:0]         o_match_count,
    output logic                          o_and_result,
    output logic                          o_or_result,
    output logic                          o_sop_result,
    output logic                          o_last_result
);
    t_cfg                          r_cfg;
    logic [START_BITS-1:0]         r_start;
    t_req                          req;
    logic                          take;
    logic                          emit_free;
    t_beat                         beat;
    t_rule                         rule_in;
    logic [MASK_BITS-1:0]          match;
    logic [RULE_COUNT*DEST_BITS-1:0] dests;

    assign req = t_req'(i_req_type);
    assign o_ready = emit_free || !((req == REQ_BEAT) && i_beat_last);
    assign take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AND_MASK:  r_cfg.and_mask  <= i_cfg_data;
                CFG_OR_MASK:   r_cfg.or_mask   <= i_cfg_data;
                CFG_AND_OR_EN: r_cfg.and_or_en <= i_cfg_data[0];
                CFG_SOP_EN:    r_cfg.sop_en    <= i_cfg_data[0];
                CFG_TERM_EN:   r_cfg.term_en   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (take && (req == REQ_BEAT)) begin
            r_start <= i_beat_last ? '0 : r_start + START_BITS'(BEAT_BYTES);
        end
    end

    always_comb begin
        beat.take  = take && (req == REQ_BEAT);
        beat.last  = i_beat_last;
        beat.data  = i_beat_data;
        beat.keep  = i_beat_keep;
        beat.start = r_start;
        rule_in.offset  = i_rule_offset;
        rule_in.value   = i_rule_value;
        rule_in.compare = t_cmp'(i_rule_compare);
        rule_in.dest    = i_rule_dest;
        rule_in.enable  = i_rule_enable;
    end

    for (genvar g = 0; g < RULE_COUNT; g++) begin : g_cell
        pbrm_rule_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (take && (req == REQ_RULE) && (i_table_index == IDX_BITS'(g))),
            .i_rule  (rule_in),
            .i_beat  (beat),
            .o_match (match[g]),
            .o_dest  (dests[g*DEST_BITS +: DEST_BITS])
        );
    end

    pbrm_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_term_wr       (take && (req == REQ_TERM)),
        .i_term_idx      (i_table_index),
        .i_term_mask     (i_term_mask),
        .i_load          (beat.take && i_beat_last),
        .i_mask          (match),
        .i_dests         (dests),
        .i_take          (i_ready),
        .o_free          (emit_free),
        .o_valid         (o_valid),
        .o_dest_addr     (o_dest_addr),
        .o_dest_valid    (o_dest_valid),
        .o_matched_rules (o_matched_rules),
        .o_match_count   (o_match_count),
        .o_and_result    (o_and_result),
        .o_or_result     (o_or_result),
        .o_sop_result    (o_sop_result),
        .o_last_result   (o_last_result)
    );
endmodule
`default_nettype wire

// ----- design/pbrm_rule_cell.sv -----
// ----------------------------------------------------------------------------
// pbrm_rule_cell
// One rule slot: stored rule, byte compare and per-packet match bit.
// ----------------------------------------------------------------------------
`default_nettype none
module pbrm_rule_cell import pbrm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire t_rule                i_rule,
    input  wire t_beat                i_beat,
    output logic                      o_match,
    output logic [DEST_BITS-1:0]      o_dest
);
    t_rule                r_rule;
    logic                 r_en;
    logic                 r_acc;
    logic                 n_acc;
    logic [START_BITS:0]  diff;
    logic [REL_BITS-1:0]  rel;
    logic [7:0]           byte_val;
    logic                 hit;
    logic                 cmp_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_rule <= i_rule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_acc <= 1'b0;
        end else begin
            if (i_wr) begin
                r_en <= i_rule.enable;
            end
            r_acc <= n_acc;
        end
    end

    always_comb begin
        diff     = {{(START_BITS+1-OFFSET_BITS){1'b0}}, r_rule.offset}
                 - {1'b0, i_beat.start};
        rel      = diff[REL_BITS-1:0];
        byte_val = i_beat.data[rel*8 +: 8];
        unique case (r_rule.compare)
            CMP_EQ:    cmp_ok = (byte_val == r_rule.value);
            CMP_LT:    cmp_ok = (byte_val <  r_rule.value);
            CMP_GT:    cmp_ok = (byte_val >  r_rule.value);
            default:   cmp_ok = 1'b0;
        endcase
        hit = r_en && !diff[START_BITS]
            && (diff < (START_BITS+1)'(BEAT_BYTES))
            && i_beat.keep[rel] && cmp_ok;
        o_match = r_acc | hit;
        if (i_beat.take) begin
            n_acc = i_beat.last ? 1'b0 : o_match;
        end else begin
            n_acc = r_acc;
        end
    end

    assign o_dest = r_rule.dest;
endmodule
`default_nettype wire

// ----- design/pbrm_emit.sv -----
// ----------------------------------------------------------------------------
// pbrm_emit
// Packet summary snapshot and output serializer, one result per cycle while i_take is high.
// ----------------------------------------------------------------------------
`default_nettype none
module pbrm_emit import pbrm_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cfg                          i_cfg,
    input  wire logic                          i_term_wr,
    input  wire logic [IDX_BITS-1:0]           i_term_idx,
    input  wire logic [MASK_BITS-1:0]          i_term_mask,
    input  wire logic                          i_load,
    input  wire logic [MASK_BITS-1:0]          i_mask,
    input  wire logic [RULE_COUNT*DEST_BITS-1:0] i_dests,
    input  wire logic                          i_take,
    output logic                               o_free,
    output logic                               o_valid,
    output logic [DEST_BITS-1:0]               o_dest_addr,
    output logic                               o_dest_valid,
    output logic [MASK_BITS-1:0]               o_matched_rules,
    output logic [COUNT_BITS-1:0]              o_match_count,
    output logic                               o_and_result,
    output logic                               o_or_result,
    output logic                               o_sop_result,
    output logic                               o_last_result
);
    logic [MASK_BITS-1:0]             r_term [TERM_COUNT];
    logic [MASK_BITS-1:0]             r_mask;
    logic [MASK_BITS-1:0]             r_left;
    logic [RULE_COUNT*DEST_BITS-1:0]  r_dests;
    logic                             r_sop;
    logic                             r_busy;
    logic [MASK_BITS-1:0]             n_left;
    logic [IDX_BITS-1:0]              sel;
    logic                             sop_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TERM_COUNT; t++) begin
                r_term[t] <= '0;
            end
        end else if (i_term_wr) begin
            r_term[i_term_idx] <= i_term_mask;
        end
    end

    always_comb begin
        sop_now = 1'b0;
        for (int t = 0; t < TERM_COUNT; t++) begin
            if (i_cfg.term_en[t] && (r_term[t] != '0)
                && ((i_mask & r_term[t]) == r_term[t])) begin
                sop_now = 1'b1;
            end
        end
        sop_now = sop_now & i_cfg.sop_en;
    end

    always_comb begin
        sel = '0;
        for (int r = RULE_COUNT - 1; r >= 0; r--) begin
            if (r_left[r]) begin
                sel = IDX_BITS'(r);
            end
        end
        n_left = r_left & (r_left - 1'b1);
    end

    always_comb begin
        o_valid         = r_busy;
        o_dest_valid    = (r_left != '0);
        o_dest_addr     = o_dest_valid ? r_dests[sel*DEST_BITS +: DEST_BITS] : '0;
        o_matched_rules = r_mask;
        o_match_count   = COUNT_BITS'($countones(r_mask));
        o_and_result    = i_cfg.and_or_en && ((r_mask & i_cfg.and_mask) == i_cfg.and_mask);
        o_or_result     = i_cfg.and_or_en && ((r_mask & i_cfg.or_mask) != '0);
        o_sop_result    = r_sop;
        o_last_result   = (n_left == '0);
        o_free          = !r_busy || (i_take && o_last_result);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mask  <= i_mask;
            r_dests <= i_dests;
            r_sop   <= sop_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_left <= i_mask;
        end else if (r_busy && i_take) begin
            r_left <= n_left;
            if (o_last_result) begin
                r_busy <= 1'b0;
            end
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_left == '0)) else $error("left bits while idle");
    a_left_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_left & ~r_mask) == '0)) else $error("left outside mask");
    a_one_per_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_take && !o_last_result && !i_load) |=>
        (r_busy && ($countones(r_left) + 1 == $countones($past(r_left)))))
        else $error("result sequence skipped a rule");
endmodule
`default_nettype wire
